>>> rtl/rv_alu_pkg.sv
package rv_alu_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned DIV_STEPS = XLEN;

    typedef enum logic [4:0] {
        MODE_ADD    = 5'd0,
        MODE_SUB    = 5'd1,
        MODE_AND    = 5'd2,
        MODE_OR     = 5'd3,
        MODE_XOR    = 5'd4,
        MODE_SLL    = 5'd5,
        MODE_SRL    = 5'd6,
        MODE_SRA    = 5'd7,
        MODE_SLT    = 5'd8,
        MODE_SLTU   = 5'd9,
        MODE_MUL    = 5'd10,
        MODE_MULH   = 5'd11,
        MODE_MULHSU = 5'd12,
        MODE_MULHU  = 5'd13,
        MODE_DIV    = 5'd14,
        MODE_DIVU   = 5'd15,
        MODE_REM    = 5'd16,
        MODE_REMU   = 5'd17
    } mode_t;

    // rem/quo hold the product halves for multiplies, and the partial
    // remainder / shifting dividend-quotient for divides.
    typedef struct packed {
        mode_t             mode;
        logic [XLEN-1:0]   res;
        logic [XLEN-1:0]   rem;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   dvs;
        logic              dv;
        logic              neg_q;
        logic              neg_r;
    } pipe_t;

endpackage

>>> rtl/rv32im_alu.sv
// Throughput: one request per cycle unless stalled; the divider retires
// one quotient bit per stage over 32 stages; the multiply fills one stage.
// The whole pipe holds while the output register is full and not taken.
// Reset (aresetn low, synchronous) empties every stage; data is not cleared.
module rv32im_alu
    import rv_alu_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [XLEN-1:0] s_operand_a,
    input  logic [XLEN-1:0] s_operand_b,
    input  logic [4:0]      s_mode,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XLEN-1:0] m_result
);

    pipe_t              pre_stage;
    pipe_t              pipe_reg  [DIV_STEPS+1];
    pipe_t              pipe_next [DIV_STEPS+1];
    logic [DIV_STEPS:0] vld_reg;
    logic               m_valid_reg;
    logic [XLEN-1:0]    m_result_reg;
    logic [XLEN-1:0]    result_next;
    logic               advance;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = m_valid_reg;
    assign m_result = m_result_reg;

    rv_alu_pre u_pre (
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .mode      (s_mode),
        .stage     (pre_stage)
    );

    assign pipe_next[0] = pre_stage;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rv_alu_div_step u_step (
            .stage_in  (pipe_reg[i]),
            .stage_out (pipe_next[i+1])
        );
    end

    rv_alu_post u_post (
        .stage  (pipe_reg[DIV_STEPS]),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            vld_reg     <= {vld_reg[DIV_STEPS-1:0], s_valid};
            m_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
            m_result_reg <= result_next;
        end
    end

    a_ready_tracks_out: assert property (@(posedge aclk)
        aresetn |-> s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule

>>> rtl/rv_alu_pre.sv
module rv_alu_pre
    import rv_alu_pkg::*;
(
    input  logic [XLEN-1:0] operand_a,
    input  logic [XLEN-1:0] operand_b,
    input  logic [4:0]      mode,
    output pipe_t           stage
);

    mode_t             op;
    logic [4:0]        sh;
    logic [2*XLEN-1:0] prod;
    logic              sgn;
    logic              an;
    logic              bn;

    always_comb begin
        op   = mode_t'(mode);
        sh   = operand_b[4:0];
        prod = (2*XLEN)'(operand_a) * (2*XLEN)'(operand_b);
        sgn  = (op == MODE_DIV) || (op == MODE_REM);
        an   = sgn & operand_a[XLEN-1];
        bn   = sgn & operand_b[XLEN-1];

        stage       = '0;
        stage.mode  = op;
        stage.res   = '0;
        case (op)
            MODE_ADD:  stage.res = operand_a + operand_b;
            MODE_SUB:  stage.res = operand_a - operand_b;
            MODE_AND:  stage.res = operand_a & operand_b;
            MODE_OR:   stage.res = operand_a | operand_b;
            MODE_XOR:  stage.res = operand_a ^ operand_b;
            MODE_SLL:  stage.res = operand_a << sh;
            MODE_SRL:  stage.res = operand_a >> sh;
            MODE_SRA:  stage.res = XLEN'($signed(operand_a) >>> sh);
            MODE_SLT:  stage.res = XLEN'($signed(operand_a) < $signed(operand_b));
            MODE_SLTU: stage.res = XLEN'(operand_a < operand_b);
            default:   stage.res = '0;
        endcase

        if (op inside {MODE_DIV, MODE_DIVU, MODE_REM, MODE_REMU}) begin
            stage.dv    = 1'b1;
            stage.rem   = '0;
            stage.quo   = an ? (XLEN'(0) - operand_a) : operand_a;
            stage.dvs   = bn ? (XLEN'(0) - operand_b) : operand_b;
            // divide by zero keeps the all-ones quotient unsigned
            stage.neg_q = (an ^ bn) & (operand_b != '0);
            stage.neg_r = an;
        end else begin
            stage.dv  = 1'b0;
            stage.quo = prod[XLEN-1:0];
            stage.rem = prod[2*XLEN-1:XLEN];
            // high-product sign correction, subtracted at the output
            case (op)
                MODE_MULH:   stage.dvs = (operand_a[XLEN-1] ? operand_b : '0)
                                       + (operand_b[XLEN-1] ? operand_a : '0);
                MODE_MULHSU: stage.dvs = operand_a[XLEN-1] ? operand_b : '0;
                default:     stage.dvs = '0;
            endcase
        end
    end

endmodule

>>> rtl/rv_alu_div_step.sv
module rv_alu_div_step
    import rv_alu_pkg::*;
(
    input  pipe_t stage_in,
    output pipe_t stage_out
);

    logic [XLEN:0] shifted;
    logic          ge;

    always_comb begin
        shifted   = {stage_in.rem, stage_in.quo[XLEN-1]};
        ge        = shifted >= {1'b0, stage_in.dvs};
        stage_out = stage_in;
        if (stage_in.dv) begin
            stage_out.rem = ge ? XLEN'(shifted - {1'b0, stage_in.dvs}) : shifted[XLEN-1:0];
            stage_out.quo = {stage_in.quo[XLEN-2:0], ge};
        end
    end

endmodule

>>> rtl/rv_alu_post.sv
module rv_alu_post
    import rv_alu_pkg::*;
(
    input  pipe_t           stage,
    output logic [XLEN-1:0] result
);

    always_comb begin
        case (stage.mode)
            MODE_MUL:    result = stage.quo;
            MODE_MULH,
            MODE_MULHSU,
            MODE_MULHU:  result = stage.rem - stage.dvs;
            MODE_DIV,
            MODE_DIVU:   result = stage.neg_q ? (XLEN'(0) - stage.quo) : stage.quo;
            MODE_REM,
            MODE_REMU:   result = stage.neg_r ? (XLEN'(0) - stage.rem) : stage.rem;
            default:     result = stage.res;
        endcase
    end

endmodule

>>> verif/rv32im_alu_test.sv
`timescale 1ns / 100ps

module rv32im_alu_test;
    import rv_alu_pkg::*;

    localparam int LATENCY      = DIV_STEPS + 1;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  mode;
        logic        known;
        logic [31:0] value;
    } vector_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_operand_a;
    logic [31:0] s_operand_b;
    logic [4:0]  s_mode;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result;

    logic [31:0] result_queue[$];
    vector_t     vectors[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_off;
    bit          stimulus_done;

    rv32im_alu DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_mode      (s_mode),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [31:0] alu_result(logic [31:0] a, logic [31:0] b,
                                               logic [4:0] mode);
        logic [4:0]  sh;
        logic [63:0] prod;
        logic [31:0] hi;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        sh   = b[4:0];
        prod = {32'd0, a} * {32'd0, b};
        hi   = prod[63:32];
        ma   = a[31] ? -a : a;
        mb   = b[31] ? -b : b;
        case (mode)
            MODE_ADD:    return a + b;
            MODE_SUB:    return a - b;
            MODE_AND:    return a & b;
            MODE_OR:     return a | b;
            MODE_XOR:    return a ^ b;
            MODE_SLL:    return a << sh;
            MODE_SRL:    return a >> sh;
            MODE_SRA:    return $unsigned($signed(a) >>> sh);
            MODE_SLT:    return {31'd0, $signed(a) < $signed(b)};
            MODE_SLTU:   return {31'd0, a < b};
            MODE_MUL:    return prod[31:0];
            MODE_MULH:   return hi - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
            MODE_MULHSU: return hi - (a[31] ? b : 32'd0);
            MODE_MULHU:  return hi;
            MODE_DIV: begin
                if (b == 0) return ONES;
                if (a == MINV && b == ONES) return a;
                q = ma / mb;
                return (a[31] != b[31]) ? -q : q;
            end
            MODE_DIVU:   return (b == 0) ? ONES : a / b;
            MODE_REM: begin
                if (b == 0) return a;
                if (a == MINV && b == ONES) return 32'd0;
                q = ma % mb;
                return a[31] ? -q : q;
            end
            MODE_REMU:   return (b == 0) ? a : a % b;
            default:     return 32'd0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 40);
            1:       return -$urandom_range(0, 40);
            2:       return MINV ^ $urandom_range(0, 3);
            3:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [31:0] a, logic [31:0] b, logic [4:0] mode,
                           logic known = 1'b0, logic [31:0] value = 32'd0);
        vector_t v;
        v.a = a; v.b = b; v.mode = mode; v.known = known; v.value = value;
        vectors.push_back(v);
    endtask

    // send one request; hold payload until accepted
    task automatic send_request(vector_t v);
        s_valid     <= 1'b1;
        s_operand_a <= v.a;
        s_operand_b <= v.b;
        s_mode      <= v.mode;
        result_queue.push_back(v.known ? v.value : alu_result(v.a, v.b, v.mode));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        int gap;
        vector_t v;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_operand_a <= '0;
        s_operand_b <= '0;
        s_mode      <= MODE_ADD;
        mismatches    = 0;
        stimulus_done = 0;

        add_row(ONES, 32'd1, MODE_ADD, 1'b1, 32'd0);
        add_row(32'd0, 32'd1, MODE_SUB, 1'b1, ONES);
        add_row(ONES, 32'h0F0F_0F0F, MODE_AND, 1'b1, 32'h0F0F_0F0F);
        add_row(32'd0, ONES, MODE_OR, 1'b1, ONES);
        add_row(ONES, ONES, MODE_XOR, 1'b1, 32'd0);
        add_row(32'd1, 32'hFFFF_FFFF, MODE_SLL, 1'b1, MINV);
        add_row(MINV, 32'h0000_003F, MODE_SRL, 1'b1, 32'd1);
        add_row(MINV, 32'd31, MODE_SRA, 1'b1, ONES);
        add_row(MINV, 32'd0, MODE_SLT, 1'b1, 32'd1);
        add_row(MINV, 32'd0, MODE_SLTU, 1'b1, 32'd0);
        add_row(ONES, ONES, MODE_MUL, 1'b1, 32'd1);
        add_row(MINV, MINV, MODE_MULH);
        add_row(ONES, ONES, MODE_MULHSU);
        add_row(ONES, ONES, MODE_MULHU, 1'b1, 32'hFFFF_FFFE);
        add_row(32'd7, 32'd0, MODE_DIV, 1'b1, ONES);
        add_row(32'd7, 32'd0, MODE_DIVU, 1'b1, ONES);
        add_row(32'd7, 32'd0, MODE_REM, 1'b1, 32'd7);
        add_row(32'd7, 32'd0, MODE_REMU, 1'b1, 32'd7);
        add_row(MINV, ONES, MODE_DIV, 1'b1, MINV);
        add_row(MINV, ONES, MODE_REM, 1'b1, 32'd0);
        add_row(-32'd7, 32'd2, MODE_DIV, 1'b1, -32'd3);
        add_row(-32'd7, 32'd2, MODE_REM, 1'b1, ONES);
        add_row(ONES, 32'd3, MODE_DIVU);
        add_row(32'h1234_5678, 32'd9, MODE_REMU);
        add_row(32'h1234_5678, 32'd9, 5'd31, 1'b1, 32'd0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (vectors[i]) send_request(vectors[i]);

        for (int n = 0; n < RANDOM_ITEMS; ) begin
            // burst, then an optional gap
            for (int k = $urandom_range(1, 30); k > 0 && n < RANDOM_ITEMS; k--, n++) begin
                v.a = random_operand();
                v.b = ($urandom_range(0, 7) == 0) ? 32'd0 :
                      ($urandom_range(0, 9) == 0) ? ONES : random_operand();
                if ($urandom_range(0, 15) == 0) v.a = MINV;
                v.mode  = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                                        : 5'($urandom_range(0, 17));
                v.known = 1'b0;
                v.value = '0;
                send_request(v);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1;
    end

    // receiver stall pattern, with one long hold-off during the random part
    initial begin
        hold_off = 0;
        @(posedge aresetn);
        repeat (300) @(posedge aclk);
        hold_off = 1;
        repeat (150) @(posedge aclk);
        hold_off = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 1) != 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", m_result, 32'd0);
            end else begin
                if (m_result !== result_queue[0])
                    report_mismatch("result", m_result, result_queue[0]);
                void'(result_queue.pop_front());
            end
        end
    end

    // watchdog, and end of run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", result_queue.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && result_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && result_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
